>>> rtl/brf_pkg.sv
// Shared types, constants and helpers for the bracketed root finder.
package brf_pkg;

  localparam int unsigned FractionBitsDefault = 16;
  localparam int unsigned TolBits            = 16;
  localparam int unsigned CfgIdxWidth        = 3;
  localparam int unsigned CfgDataWidth       = 32;

  // Configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegCoeffSquare   = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegCoeffLinear   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegCoeffConstant = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegTolerance     = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegIterationCap  = 3'd4;

  // Result status codes
  localparam logic [1:0] StatusConverged = 2'd0;
  localparam logic [1:0] StatusNoSign    = 2'd1;
  localparam logic [1:0] StatusLimit     = 2'd2;

  // Method codes
  localparam logic OpBisect   = 1'b0;
  localparam logic OpFalsePos = 1'b1;

  localparam logic [15:0] ToleranceReset = 16'd66;
  localparam logic [7:0]  CapReset       = 8'd64;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // take new bracket from the input transfer
    logic eval_start; // start f(x) evaluation
    logic [1:0] eval_sel; // 0 lo, 1 hi, 2 new estimate
    logic est_start;  // start estimate computation
    logic update;     // narrow bracket, bump count, run convergence test
  } brf_cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic eval_done;
    logic est_done;
    logic sign_ok;    // f(lo), f(hi) of opposite sign
    logic conv;       // convergence test result, valid after update
    logic at_cap;     // count has reached the cap, valid after update
  } brf_stat_t;

  localparam logic [1:0] SelLo  = 2'd0;
  localparam logic [1:0] SelHi  = 2'd1;
  localparam logic [1:0] SelNew = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    else if (v < -66'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic opposite(input logic signed [31:0] p,
                                    input logic signed [31:0] q);
    return (p[31] && (q != 0) && !q[31]) || (q[31] && (p != 0) && !p[31]);
  endfunction

endpackage

>>> rtl/brf_stream_if.sv
// Valid/ready channel carrying a payload of a given type.
interface brf_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/brf_ctrl.sv
// Controller state machine sequencing evaluations, estimates and results.
module brf_ctrl
  import brf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output logic [1:0] status_o,
  output brf_cmd_t  cmd_o,
  input  brf_stat_t stat_i
);

  typedef enum logic [3:0] {
    StIdle, StEvLo, StWLo, StEvHi, StWHi, StTest, StEst, StWEst,
    StEvNew, StWNew, StUpd, StDecide, StOut
  } state_e;

  state_e     state_q;
  logic [1:0] status_q;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign status_o    = status_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle:  cmd_o.load = in_valid_i;
      StEvLo:  begin cmd_o.eval_start = 1'b1; cmd_o.eval_sel = SelLo; end
      StEvHi:  begin cmd_o.eval_start = 1'b1; cmd_o.eval_sel = SelHi; end
      StEst:   cmd_o.est_start = 1'b1;
      StEvNew: begin cmd_o.eval_start = 1'b1; cmd_o.eval_sel = SelNew; end
      StUpd:   cmd_o.update = 1'b1;
      default: ;
    endcase
  end

  // State and registered status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      status_q <= StatusConverged;
    end else begin
      case (state_q)
        StIdle:   if (in_valid_i) state_q <= StEvLo;
        StEvLo:   state_q <= StWLo;
        StWLo:    if (stat_i.eval_done) state_q <= StEvHi;
        StEvHi:   state_q <= StWHi;
        StWHi:    if (stat_i.eval_done) state_q <= StTest;
        StTest: begin
          if (stat_i.sign_ok) state_q <= StEst;
          else begin
            status_q <= StatusNoSign;
            state_q  <= StOut;
          end
        end
        StEst:    state_q <= StWEst;
        StWEst:   if (stat_i.est_done) state_q <= StEvNew;
        StEvNew:  state_q <= StWNew;
        StWNew:   if (stat_i.eval_done) state_q <= StUpd;
        StUpd:    state_q <= StDecide;
        StDecide: begin
          if (stat_i.conv) begin
            status_q <= StatusConverged;
            state_q  <= StOut;
          end else if (stat_i.at_cap) begin
            status_q <= StatusLimit;
            state_q  <= StOut;
          end else begin
            state_q <= StEvLo;
          end
        end
        StOut:    if (out_ready_i) state_q <= StIdle;
        default:  state_q <= StIdle;
      endcase
    end
  end

endmodule

>>> rtl/brf_datapath.sv
// Datapath: bracket registers, shared polynomial unit, serial divider, test.
module brf_datapath
  import brf_pkg::*;
#(
  parameter int unsigned FractionBits = FractionBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               op_i,
  input  logic signed [31:0] lower_i,
  input  logic signed [31:0] upper_i,
  input  logic signed [31:0] coeff_square_i,
  input  logic signed [31:0] coeff_linear_i,
  input  logic signed [31:0] coeff_constant_i,
  input  logic [15:0]        tolerance_i,
  input  logic [7:0]         cap_i,
  input  logic               no_sign_i,
  input  brf_cmd_t           cmd_i,
  output brf_stat_t          stat_o,
  output logic signed [31:0] root_o,
  output logic [7:0]         iterations_o
);

  logic               op_q;
  logic signed [31:0] lo_q, hi_q, prev_q, now_q, flo_q, fhi_q, fnow_q;
  logic [7:0]         n_q;
  logic               conv_q;

  // ---------------- polynomial unit: 4 steps ----------------
  logic [2:0]         ph_q;      // 0 idle, 1..4 steps
  logic [1:0]         sel_q;
  logic signed [31:0] x_q;
  logic signed [63:0] prod_q;
  logic signed [31:0] sq_q;
  logic signed [63:0] t1_q;
  logic signed [63:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic               eval_done;

  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (ph_q)
      3'd1:    begin mul_a = 64'(x_q); mul_b = 64'(x_q); end
      3'd2:    begin mul_a = 64'(coeff_linear_i); mul_b = 64'(x_q); end
      3'd3:    begin mul_a = 64'(coeff_square_i); mul_b = 64'(sq_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  logic signed [31:0] fval;
  assign fval = sat32(66'(prod_q >>> FractionBits) + 66'(t1_q) + 66'(coeff_constant_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= '0;
      eval_done <= 1'b0;
    end else begin
      eval_done <= 1'b0;
      if (cmd_i.eval_start) ph_q <= 3'd1;
      else if (ph_q == 3'd4) begin
        ph_q      <= '0;
        eval_done <= 1'b1;
      end else if (ph_q != 3'd0) ph_q <= ph_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_start) begin
      sel_q <= cmd_i.eval_sel;
      case (cmd_i.eval_sel)
        SelLo:   x_q <= lo_q;
        SelHi:   x_q <= hi_q;
        default: x_q <= now_q;
      endcase
    end
    case (ph_q)
      3'd1: prod_q <= mul_p;
      3'd2: begin
        sq_q <= sat32(66'(prod_q >>> FractionBits));
        t1_q <= mul_p >>> FractionBits;
      end
      3'd3: prod_q <= mul_p;
      3'd4: begin
        case (sel_q)
          SelLo:   flo_q  <= fval;
          SelHi:   fhi_q  <= fval;
          default: fnow_q <= fval;
        endcase
      end
      default: ;
    endcase
  end

  // ---------------- estimate: midpoint or false position ----------------
  // num = fhi*(lo-hi) fits 65 bits; den = flo-fhi, 33 bits; restoring divide
  localparam int unsigned NumW = 66;
  logic [1:0]         eph_q;     // 0 idle, 1 setup, 2 divide, 3 finish
  logic [6:0]         dcnt_q;
  logic [NumW-1:0]    quo_q;
  logic [33:0]        rem_q;
  logic [32:0]        dmag_q;
  logic               qneg_q;
  logic signed [65:0] num_q;
  logic signed [33:0] den_q;
  logic               est_done;
  logic signed [32:0] lmh;
  logic signed [65:0] numw;
  logic [NumW-1:0]    nmag;
  logic [34:0]        rtry;
  logic signed [66:0] qs;

  assign lmh  = 33'(lo_q) - 33'(hi_q);
  assign numw = 66'(fhi_q) * 66'(lmh);
  assign nmag = num_q[65] ? NumW'(-num_q) : NumW'(num_q);
  assign rtry = {rem_q, quo_q[NumW-1]} - {2'b0, dmag_q};
  assign qs   = qneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eph_q    <= '0;
      est_done <= 1'b0;
      dcnt_q   <= '0;
    end else begin
      est_done <= 1'b0;
      case (eph_q)
        2'd0: if (cmd_i.est_start) begin
          if (op_q == OpFalsePos) eph_q <= 2'd1;
          else begin
            est_done <= 1'b1;
          end
        end
        2'd1: begin eph_q <= 2'd2; dcnt_q <= 7'(NumW); end
        2'd2: begin
          if (dcnt_q == 7'd1) eph_q <= 2'd3;
          dcnt_q <= dcnt_q - 7'd1;
        end
        2'd3: begin eph_q <= '0; est_done <= 1'b1; end
        default: eph_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (eph_q == 2'd0 && cmd_i.est_start) begin
      num_q <= numw;
      den_q <= 34'(flo_q) - 34'(fhi_q);
      if (op_q == OpBisect)
        now_q <= 32'((33'(lo_q) + 33'(hi_q)) >>> 1);
    end
    if (eph_q == 2'd1) begin
      quo_q  <= nmag;
      rem_q  <= '0;
      dmag_q <= den_q[33] ? 33'(-den_q) : 33'(den_q);
      qneg_q <= num_q[65] ^ den_q[33];
    end
    if (eph_q == 2'd2) begin
      if (!rtry[34]) begin
        rem_q <= rtry[33:0];
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[32:0], quo_q[NumW-1]};
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
    if (eph_q == 2'd3)
      now_q <= sat32(66'(hi_q) - qs[65:0]);
  end

  // ---------------- bracket update and convergence ----------------
  logic signed [32:0] diff;
  logic [32:0]        dmagn, amag;
  logic [48:0]        lhs, rhs;
  assign diff  = 33'(now_q) - 33'(prev_q);
  assign dmagn = diff[32] ? 33'(-diff) : 33'(diff);
  assign amag  = now_q[31] ? 33'(-33'(now_q)) : 33'(now_q);
  assign lhs   = {dmagn[32:0], 16'd0};
  assign rhs   = 49'(tolerance_i) * 49'(amag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= '0;
      hi_q   <= '0;
      prev_q <= '0;
      n_q    <= '0;
      op_q   <= 1'b0;
      conv_q <= 1'b0;
    end else if (cmd_i.load) begin
      lo_q   <= lower_i;
      hi_q   <= upper_i;
      prev_q <= '0;
      n_q    <= '0;
      op_q   <= op_i;
    end else if (cmd_i.update) begin
      if (opposite(flo_q, fnow_q)) hi_q <= now_q;
      else if (opposite(fnow_q, fhi_q)) lo_q <= now_q;
      prev_q <= now_q;
      n_q    <= n_q + 8'd1;
      conv_q <= (dmagn == 0) || (lhs < rhs);
    end
  end

  assign stat_o.eval_done = eval_done;
  assign stat_o.est_done  = est_done;
  assign stat_o.sign_ok   = opposite(flo_q, fhi_q);
  assign stat_o.conv      = conv_q;
  assign stat_o.at_cap    = (n_q >= ((cap_i == 8'd0) ? 8'd1 : cap_i));
  assign root_o           = no_sign_i ? 32'sd0 : now_q;
  assign iterations_o     = n_q;

endmodule

>>> rtl/bracketed_root_finder.sv
// Top level of the bracketed root finder: config registers, control, datapath.
//
//  channel  dir  payload
//  in_s     in   opcode, lower_bound, upper_bound
//  out_m    out  root, iterations, status
//  cfg_*    in   write enable, index, data
//
// One item at a time. Each evaluation of f is a launch, 4 steps on one
// multiplier and done. An iteration is three evaluations plus sign test,
// estimate, update and decide; false position adds a divider (setup,
// 66 restoring steps and finish). A bracket without sign change on entry
// is reported without iterating. Reset is asynchronous and restores the
// coefficient defaults. The result holds in its register until taken;
// input is accepted only when idle.
module bracketed_root_finder
  import brf_pkg::*;
#(
  parameter int unsigned FractionBits = FractionBitsDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  brf_stream_if.sink             in_s,
  brf_stream_if.source           out_m,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  logic signed [31:0] csq_q, clin_q, ccon_q;
  logic [15:0]        tol_q;
  logic [7:0]         cap_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      csq_q  <= -(32'sd1 <<< (FractionBits - 1));
      clin_q <= 32'sd5 <<< (FractionBits - 1);
      ccon_q <= 32'sd9 <<< (FractionBits - 1);
      tol_q  <= ToleranceReset;
      cap_q  <= CapReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCoeffSquare:   csq_q  <= cfg_data_i;
        RegCoeffLinear:   clin_q <= cfg_data_i;
        RegCoeffConstant: ccon_q <= cfg_data_i;
        RegTolerance:     tol_q  <= cfg_data_i[15:0];
        RegIterationCap:  cap_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  brf_cmd_t   cmd;
  brf_stat_t  stat;
  logic [1:0] status;

  brf_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_m.valid),
    .out_ready_i (out_m.ready),
    .status_o    (status),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  brf_datapath #(.FractionBits(FractionBits)) u_dp (
    .clk_i, .rst_ni,
    .op_i             (in_s.data.opcode),
    .lower_i          (in_s.data.lower_bound),
    .upper_i          (in_s.data.upper_bound),
    .coeff_square_i   (csq_q),
    .coeff_linear_i   (clin_q),
    .coeff_constant_i (ccon_q),
    .tolerance_i      (tol_q),
    .cap_i            (cap_q),
    .no_sign_i        (status == StatusNoSign),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .root_o           (out_m.data.root),
    .iterations_o     (out_m.data.iterations)
  );

  assign out_m.data.status = status;

  // Never ready for input while a result is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_s.ready && out_m.valid))
    else $error("input and output both open");
  // A transfer out leaves the block idle next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid && out_m.ready |=> in_s.ready)
    else $error("not idle after result transfer");
  // Result never reports more iterations than the cap allows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_m.valid |-> out_m.data.iterations <= ((cap_q == 8'd0) ? 8'd1 : cap_q))
    else $error("iteration count beyond cap");

endmodule
